[sv/ecg_pkg.sv]
// ----------------------------------------------------------------------------
// Error detection code generator package
// Shared types and constants for the front, queue and back of the generator.
// ----------------------------------------------------------------------------
package ecg_pkg;

  // Default row limit of the two-dimensional parity.
  localparam int MaxRowsDefault = 32;

  // Number of jobs held between the front and the back.
  localparam int QueueDepth = 2;

  // Bytes in one row of the two-dimensional parity.
  localparam int RowBytes = 8;

  // Code selected by the mode register.
  typedef enum logic [2:0] {
    MODE_PARITY  = 3'd0,
    MODE_PARITY2 = 3'd1,
    MODE_CRC     = 3'd2,
    MODE_HAMMING = 3'd3,
    MODE_CSUM    = 3'd4
  } mode_e;

  // Kind of one result item.
  typedef enum logic [2:0] {
    KIND_PARITY  = 3'd0,
    KIND_ROW     = 3'd1,
    KIND_COLUMN  = 3'd2,
    KIND_CRC     = 3'd3,
    KIND_HAMMING = 3'd4,
    KIND_CSUM    = 3'd5
  } kind_e;

  // One job: an optional single result followed by optional column results.
  typedef struct packed {
    logic                           main_vld;
    logic [15:0]                    main_val;
    kind_e                          main_kind;
    logic                           main_last;
    logic                           cols_vld;
    logic [RowBytes-1:0][7:0]       cols;
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Back-end activity, for the checks at the top level.
  typedef struct packed {
    logic load;
    logic pop;
  } bk_status_t;

endpackage

[sv/ecg_front.sv]
// ----------------------------------------------------------------------------
// Error detection code generator front end
// Accepts message bytes, updates every code accumulator and turns each byte
// into a job that tells the back end which results to send.
// ----------------------------------------------------------------------------
module ecg_front #(
  parameter int MAX_ROWS = ecg_pkg::MaxRowsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_data_i,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output ecg_pkg::job_t     job_o,
  output logic              job_vld_o
);

  localparam int MaxBytes = MAX_ROWS * ecg_pkg::RowBytes;
  localparam int CountW   = $clog2(MaxBytes + 1);
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // One CRC-16 byte update, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Hamming(12,8) check nibble: p1 bit 0, p2 bit 1, p4 bit 2, p8 bit 3.
  function automatic logic [3:0] ham_nibble(input logic [7:0] b);
    logic [3:0] p;
    p[0] = b[0] ^ b[1] ^ b[3] ^ b[4] ^ b[6];
    p[1] = b[0] ^ b[2] ^ b[3] ^ b[5] ^ b[6];
    p[2] = b[1] ^ b[2] ^ b[3] ^ b[7];
    p[3] = b[4] ^ b[5] ^ b[6] ^ b[7];
    return p;
  endfunction

  logic [2:0]             mode_q;
  logic                   par_q, par_d;
  logic [15:0]            crc_q, crc_d;
  logic [15:0]            sum_q, sum_d;
  logic [7:0]             pend_q;
  logic                   high_q;
  logic [CountW-1:0]      count_q;
  logic [7:0]             row_q, row_d;
  logic [7:0][7:0]        col_q, col_d;

  logic                   in_rows;
  logic [2:0]             col_idx;
  logic [2:0]             idx_next;
  logic                   emit_row;
  logic [15:0]            csum_word;
  logic                   csum_add;
  logic [16:0]            csum_raw;
  ecg_pkg::job_t          job;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ecg_pkg::MODE_PARITY;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Accumulator updates for the current byte.
  always_comb begin
    par_d    = par_q ^ (^byte_i);
    crc_d    = crc_byte(crc_q, byte_i);

    // A last byte without its partner is padded with a zero low byte.
    csum_word = high_q ? {pend_q, byte_i} : {byte_i, 8'h00};
    csum_add  = high_q || last_i;
    csum_raw  = {1'b0, sum_q} + {1'b0, csum_word};
    sum_d     = csum_add ? (csum_raw[15:0] + {15'd0, csum_raw[16]}) : sum_q;

    in_rows  = count_q < CountW'(MaxBytes);
    col_idx  = count_q[2:0];
    idx_next = col_idx + 3'd1;
    row_d    = in_rows ? (row_q ^ byte_i) : row_q;
    col_d    = col_q;
    if (in_rows) begin
      col_d[col_idx] = col_q[col_idx] ^ byte_i;
    end
    // A full row, or a partial row closed by the last byte.
    emit_row = in_rows && ((idx_next == 3'd0) || last_i);
  end

  // Job built from the mode in force at this byte.
  always_comb begin
    job           = '0;
    job.main_kind = ecg_pkg::KIND_PARITY;
    job.cols      = col_d;
    unique case (mode_q)
      ecg_pkg::MODE_PARITY: begin
        job.main_vld  = last_i;
        job.main_val  = {15'd0, par_d};
        job.main_kind = ecg_pkg::KIND_PARITY;
        job.main_last = 1'b1;
      end
      ecg_pkg::MODE_PARITY2: begin
        job.main_vld  = emit_row;
        job.main_val  = {8'd0, row_d};
        job.main_kind = ecg_pkg::KIND_ROW;
        job.main_last = 1'b0;
        job.cols_vld  = last_i;
      end
      ecg_pkg::MODE_CRC: begin
        job.main_vld  = last_i;
        job.main_val  = crc_d;
        job.main_kind = ecg_pkg::KIND_CRC;
        job.main_last = 1'b1;
      end
      ecg_pkg::MODE_HAMMING: begin
        job.main_vld  = 1'b1;
        job.main_val  = {12'd0, ham_nibble(byte_i)};
        job.main_kind = ecg_pkg::KIND_HAMMING;
        job.main_last = last_i;
      end
      ecg_pkg::MODE_CSUM: begin
        job.main_vld  = last_i;
        job.main_val  = ~sum_d;
        job.main_kind = ecg_pkg::KIND_CSUM;
        job.main_last = 1'b1;
      end
      default: begin
        job.main_vld = 1'b0;
      end
    endcase
  end

  assign job_o     = job;
  assign job_vld_o = accept_i && (job.main_vld || job.cols_vld);

  // Accumulator registers; the last byte returns them to their reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q   <= 1'b0;
      crc_q   <= CrcInit;
      sum_q   <= '0;
      pend_q  <= '0;
      high_q  <= 1'b0;
      count_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        par_q   <= 1'b0;
        crc_q   <= CrcInit;
        sum_q   <= '0;
        pend_q  <= '0;
        high_q  <= 1'b0;
        count_q <= '0;
        row_q   <= '0;
        col_q   <= '0;
      end else begin
        par_q   <= par_d;
        crc_q   <= crc_d;
        sum_q   <= sum_d;
        pend_q  <= high_q ? 8'h00 : byte_i;
        high_q  <= !high_q;
        count_q <= in_rows ? (count_q + CountW'(1)) : count_q;
        row_q   <= emit_row ? 8'h00 : row_d;
        col_q   <= col_d;
      end
    end
  end

endmodule

[sv/ecg_queue.sv]
// ----------------------------------------------------------------------------
// Error detection code generator job queue
// A short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module ecg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ecg_pkg::job_t       job_i,
  input  logic                pop_i,
  output ecg_pkg::job_t       head_o,
  output ecg_pkg::q_status_t  status_o
);

  localparam int Depth  = ecg_pkg::QueueDepth;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  ecg_pkg::job_t          slot_q [Depth];
  logic [PtrW-1:0]        wr_q, rd_q;
  logic [CountW-1:0]      count_q;

  // Pointer advance with wrap at the depth.
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : (p + PtrW'(1));
  endfunction

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CountW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

  assign head_o             = slot_q[rd_q];
  assign status_o.full      = count_q == CountW'(Depth);
  assign status_o.not_empty = count_q != '0;

endmodule

[sv/ecg_back.sv]
// ----------------------------------------------------------------------------
// Error detection code generator back end
// Walks the job at the head of the queue and sends its results, one item
// per cycle while the output is ready, through an output register.
// ----------------------------------------------------------------------------
module ecg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ecg_pkg::job_t       head_i,
  input  logic                head_vld_i,
  output ecg_pkg::bk_status_t status_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o,
  output logic [2:0]          m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  localparam logic [2:0] LastCol = 3'(ecg_pkg::RowBytes - 1);

  logic         vld_q;
  logic [15:0]  data_q;
  logic [2:0]   user_q;
  logic         last_q;
  logic         main_done_q;
  logic [2:0]   col_q;

  logic         load;
  logic         pop;
  logic         sel_main;
  logic [15:0]  val;
  logic [2:0]   kind;
  logic         last;

  // Pick the next result of the head job.
  always_comb begin
    load     = (!vld_q || m_axis_tready_i) && head_vld_i;
    sel_main = head_i.main_vld && !main_done_q;
    if (sel_main) begin
      val  = head_i.main_val;
      kind = head_i.main_kind;
      last = head_i.main_last;
      pop  = load && !head_i.cols_vld;
    end else begin
      val  = {8'd0, head_i.cols[col_q]};
      kind = ecg_pkg::KIND_COLUMN;
      last = col_q == LastCol;
      pop  = load && (col_q == LastCol);
    end
  end

  // Position inside the head job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_done_q <= 1'b0;
      col_q       <= '0;
    end else if (load) begin
      if (pop) begin
        main_done_q <= 1'b0;
        col_q       <= '0;
      end else if (sel_main) begin
        main_done_q <= 1'b1;
      end else begin
        col_q <= col_q + 3'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= val;
      user_q <= kind;
      last_q <= last;
    end
  end

  assign status_o.load  = load;
  assign status_o.pop   = pop;
  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = last_q;

endmodule

[sv/error_detect_code_generator_unit.sv]
// ----------------------------------------------------------------------------
// Error detection code generator
// Parity, two-dimensional parity, CRC-16, Hamming(12,8) and ones-complement
// checksum over a byte stream, selected by a mode register.
//
//   Channel  Direction  Contents
//   s_axis   in         tdata: byte_value[7:0]; tlast: last_byte
//   m_axis   out        tdata: code_value[15:0]; tuser: code_kind[2:0];
//                       tlast: last_result
//   cfg      in         cfg_data: mode[2:0], always ready
//
// The front takes one byte per cycle while the queue is not full and updates
// every accumulator in that cycle. The back sends one result per cycle while
// the output is ready, from a two-job queue, so a byte with up to nine results
// (two-dimensional parity at the last byte) holds the input off once the queue
// is full. Output stalls fill the queue and then stall the input. Reset clears
// all accumulators and sets the mode to even parity; no clearing pass.
// ----------------------------------------------------------------------------
module error_detect_code_generator_unit #(
  parameter int MAX_ROWS = ecg_pkg::MaxRowsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,      // mode[2:0]
  // Byte input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // byte_value[7:0]
  input  logic        s_axis_tlast_i,
  // Result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // code_value[15:0]
  output logic [2:0]  m_axis_tuser_o,  // code_kind[2:0]
  output logic        m_axis_tlast_o
);

  ecg_pkg::job_t       job;
  ecg_pkg::job_t       head;
  logic                push;
  logic                accept;
  ecg_pkg::q_status_t  q_status;
  ecg_pkg::bk_status_t bk_status;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !q_status.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  ecg_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .job_o       (job),
    .job_vld_o   (push)
  );

  ecg_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (bk_status.pop),
    .head_o   (head),
    .status_o (q_status)
  );

  ecg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_vld_i      (q_status.not_empty),
    .status_o        (bk_status),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // A job is never written into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("job pushed into a full queue");

  // A job leaves the queue only when its final result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bk_status.pop |-> bk_status.load)
    else $error("job popped without a result");

  // Every loaded result shows up on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bk_status.load |=> m_axis_tvalid_o)
    else $error("loaded result not presented");

  // A pop without a push from a queue that is not full leaves it not full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (bk_status.pop && !push && !q_status.full) |=> !q_status.full)
    else $error("queue level wrong after pop");

endmodule
